@@ rtl/rfa_pkg.sv @@
`timescale 1ns / 1ps

package rfa_pkg;

   localparam int RING_W = 7;
   localparam int SEAT_W = 6;
   localparam int ST_W   = 2;

   // five-entry window around the active seat
   localparam int NUM_SLOTS  = 5;
   localparam int SLOT_LL    = 0;
   localparam int SLOT_L     = 1;
   localparam int SLOT_SELF  = 2;
   localparam int SLOT_R     = 3;
   localparam int SLOT_RR    = 4;

   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [ST_W-1:0] ST_THINKING = 2'd0;
   localparam logic [ST_W-1:0] ST_HUNGRY   = 2'd1;
   localparam logic [ST_W-1:0] ST_EATING   = 2'd2;

   typedef struct packed {
      logic              cmd;
      logic [SEAT_W-1:0] seat;
   } req_type;

   typedef struct packed {
      logic              seat_error;
      logic              first_grant_valid;
      logic [SEAT_W-1:0] first_grant_seat;
      logic              second_grant_valid;
      logic [SEAT_W-1:0] second_grant_seat;
   } rsp_type;

   typedef struct packed {
      logic [RING_W-1:0] addr;
      logic [ST_W-1:0]   st;
   } slot_type;

   // new states of left, self and right, plus the two grant flags
   typedef struct packed {
      logic                 first_grant;
      logic                 second_grant;
      logic [2:0][ST_W-1:0] slot_st;
   } eval_type;

endpackage

@@ rtl/rfa_window_eval.sv @@
`timescale 1ns / 1ps

module rfa_window_eval (
   input  logic                                  cmd,
   input  rfa_pkg::slot_type [rfa_pkg::NUM_SLOTS-1:0] win,
   output rfa_pkg::eval_type                     res
);
   import rfa_pkg::*;

   logic [NUM_SLOTS-1:0][ST_W-1:0] st;
   logic                           g1;
   logic                           g2;

   // every update hits all slots that alias the same seat in small rings
   always_comb begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         st[k] = win[k].st;
      end
      g1 = 1'b0;
      g2 = 1'b0;
      if (cmd == CMD_REQUEST) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            if (win[k].addr == win[SLOT_SELF].addr) st[k] = ST_HUNGRY;
         end
         if (st[SLOT_SELF] == ST_HUNGRY && st[SLOT_L] != ST_EATING &&
             st[SLOT_R] != ST_EATING) begin
            g1 = 1'b1;
            for (int k = 0; k < NUM_SLOTS; k++) begin
               if (win[k].addr == win[SLOT_SELF].addr) st[k] = ST_EATING;
            end
         end
      end else begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            if (win[k].addr == win[SLOT_SELF].addr) st[k] = ST_THINKING;
         end
         // left neighbor: its own neighbors are left-left and self
         if (st[SLOT_L] == ST_HUNGRY && st[SLOT_LL] != ST_EATING &&
             st[SLOT_SELF] != ST_EATING) begin
            g1 = 1'b1;
            for (int k = 0; k < NUM_SLOTS; k++) begin
               if (win[k].addr == win[SLOT_L].addr) st[k] = ST_EATING;
            end
         end
         // right neighbor: its own neighbors are self and right-right
         if (st[SLOT_R] == ST_HUNGRY && st[SLOT_SELF] != ST_EATING &&
             st[SLOT_RR] != ST_EATING) begin
            g2 = 1'b1;
            for (int k = 0; k < NUM_SLOTS; k++) begin
               if (win[k].addr == win[SLOT_R].addr) st[k] = ST_EATING;
            end
         end
      end
   end

   assign res.first_grant  = g1;
   assign res.second_grant = g2;
   assign res.slot_st[0]   = st[SLOT_L];
   assign res.slot_st[1]   = st[SLOT_SELF];
   assign res.slot_st[2]   = st[SLOT_R];

endmodule

@@ rtl/ring_fork_arbiter.sv @@
`timescale 1ns / 1ps

// Ring fork arbiter: seats in a ring each need both neighboring forks; a request
// makes a seat hungry and grants it when no neighbor eats, a release makes it
// think and offers the forks to the left, then the right neighbor. Seat states
// live in a simple dual-port memory of MAX_SEATS entries with a registered read
// port. After reset a clearing pass writes every entry to thinking, one per
// cycle, and input stays stalled until the pass is done. An item with a seat
// in the ring is then accepted, streams in the five window entries (left-left,
// left, self, right, right-right) through the one read port, evaluates the
// grants, writes back left, self and right through the one write port, and
// hands the result to the output register. An item whose seat is outside the
// ring goes from accept straight to the hand-off and leaves the memory
// untouched. Items are processed one at a time; the next is accepted while the
// previous result may still wait on rsp_stall. The ring size register can be
// written at any time through the csr port, which is always ready.
module ring_fork_arbiter #(
   parameter int MAX_SEATS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rfa_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rfa_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rfa_pkg::RING_W-1:0]      csr_data
);
   import rfa_pkg::*;

   localparam int AW       = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
   localparam int MAX_CLIP = (MAX_SEATS > 127) ? 127 : MAX_SEATS;
   localparam logic [RING_W-1:0] MaxRing   = RING_W'(MAX_CLIP);
   localparam logic [AW-1:0]     LastEntry = AW'(MAX_SEATS - 1);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_READ  = 6'b000100,
      S_CALC  = 6'b001000,
      S_WRITE = 6'b010000,
      S_DONE  = 6'b100000
   } fsm_type;

   fsm_type                        state_ff, state_in;
   logic [AW-1:0]                  clr_ff, clr_in;
   logic [2:0]                     rd_cnt_ff, rd_cnt_in;
   logic [1:0]                     wr_cnt_ff, wr_cnt_in;
   logic                           cmd_ff, cmd_in;
   logic [NUM_SLOTS-1:0][RING_W-1:0] addr_ff, addr_in;
   logic [NUM_SLOTS-1:0][ST_W-1:0]   win_ff, win_in;
   logic [2:0][ST_W-1:0]           wr_st_ff, wr_st_in;
   rsp_type                        res_ff, res_in;
   rsp_type                        rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [RING_W-1:0]              ring_size_ff, ring_size_in;

   logic [ST_W-1:0]                mem [MAX_SEATS];
   logic [ST_W-1:0]                mem_rd_ff;
   logic [AW-1:0]                  mem_ra;
   logic                           mem_we;
   logic [AW-1:0]                  mem_wa;
   logic [ST_W-1:0]                mem_wd;

   logic [RING_W-1:0]              n_eff;
   logic [RING_W-1:0]              n_m1;
   logic [RING_W-1:0]              s7;
   logic [RING_W-1:0]              a_l, a_ll, a_r, a_rr;
   logic                           seat_bad;
   logic                           req_beat;
   logic [2:0]                     rd_idx;
   logic [2:0]                     wr_idx;

   slot_type [NUM_SLOTS-1:0]       win;
   eval_type                       ev;

   assign n_eff    = (ring_size_ff > MaxRing) ? MaxRing : ring_size_ff;
   assign n_m1     = n_eff - RING_W'(1);
   assign s7       = {1'b0, req_data.seat};
   assign seat_bad = (s7 >= n_eff);
   assign a_l      = (s7 == '0) ? n_m1 : s7 - RING_W'(1);
   assign a_ll     = (a_l == '0) ? n_m1 : a_l - RING_W'(1);
   assign a_r      = (s7 == n_m1) ? '0 : s7 + RING_W'(1);
   assign a_rr     = (a_r == n_m1) ? '0 : a_r + RING_W'(1);

   assign req_stall = (state_ff != S_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         win[k].addr = addr_ff[k];
         win[k].st   = win_ff[k];
      end
   end

   rfa_window_eval u_eval (
      .cmd (cmd_ff),
      .win (win),
      .res (ev)
   );

   assign rd_idx = (rd_cnt_ff >= 3'(NUM_SLOTS)) ? 3'd0 : rd_cnt_ff;
   assign wr_idx = {1'b0, wr_cnt_ff} + 3'd1;
   assign mem_ra = AW'(addr_ff[rd_idx]);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rd_cnt_in    = rd_cnt_ff;
      wr_cnt_in    = wr_cnt_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      win_in       = win_ff;
      wr_st_in     = wr_st_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ring_size_in = (csr_valid && csr_ready) ? csr_data : ring_size_ff;
      mem_we       = 1'b0;
      mem_wa       = clr_ff;
      mem_wd       = ST_THINKING;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LastEntry) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_beat) begin
               cmd_in = req_data.cmd;
               if (seat_bad) begin
                  res_in            = '0;
                  res_in.seat_error = 1'b1;
                  state_in          = S_DONE;
               end else begin
                  addr_in[SLOT_LL]   = a_ll;
                  addr_in[SLOT_L]    = a_l;
                  addr_in[SLOT_SELF] = s7;
                  addr_in[SLOT_R]    = a_r;
                  addr_in[SLOT_RR]   = a_rr;
                  rd_cnt_in          = '0;
                  state_in           = S_READ;
               end
            end
         end
         S_READ: begin
            // data of the read issued last cycle lands now
            if (rd_cnt_ff != 3'd0) win_in[rd_cnt_ff - 3'd1] = mem_rd_ff;
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == 3'(NUM_SLOTS)) state_in = S_CALC;
         end
         S_CALC: begin
            wr_st_in                  = ev.slot_st;
            res_in                    = '0;
            res_in.first_grant_valid  = ev.first_grant;
            res_in.second_grant_valid = ev.second_grant;
            if (ev.first_grant) begin
               res_in.first_grant_seat = (cmd_ff == CMD_RELEASE) ?
                  addr_ff[SLOT_L][SEAT_W-1:0] : addr_ff[SLOT_SELF][SEAT_W-1:0];
            end
            if (ev.second_grant) res_in.second_grant_seat = addr_ff[SLOT_R][SEAT_W-1:0];
            wr_cnt_in = '0;
            state_in  = S_WRITE;
         end
         S_WRITE: begin
            // left, self, right; aliased entries carry the same value
            mem_we    = 1'b1;
            mem_wa    = AW'(addr_ff[wr_idx]);
            mem_wd    = wr_st_ff[wr_cnt_ff];
            wr_cnt_in = wr_cnt_ff + 2'd1;
            if (wr_cnt_ff == 2'd2) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rd_cnt_ff    <= '0;
         wr_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         ring_size_ff <= RING_W'(8);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_cnt_ff    <= rd_cnt_in;
         wr_cnt_ff    <= wr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         ring_size_ff <= ring_size_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      addr_ff  <= addr_in;
      win_ff   <= win_in;
      wr_st_ff <= wr_st_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result beat raised outside the hand-off state");

   a_error_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.seat_error |->
         !rsp_ff.first_grant_valid && !rsp_ff.second_grant_valid)
      else $error("grant reported together with a seat error");

   a_distinct_grants: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.first_grant_valid && rsp_ff.second_grant_valid |->
         rsp_ff.first_grant_seat != rsp_ff.second_grant_seat)
      else $error("same seat granted twice in one beat");

   a_write_after_calc: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_WRITE) |-> $past(state_ff == S_CALC))
      else $error("write-back entered without evaluation");
`endif

endmodule
